FILE: sv/mbe_pkg.sv
// Package for the Mandelbrot escape-time core: shared types, register codes,
// reset values and the 32-bit saturation helper. No dependencies.
package mbe_pkg;

    localparam int FRAC_BITS_DEF  = 28;
    localparam int COORD_BITS_DEF = 12;
    localparam int NUM_CELLS_DEF  = 4;

    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int SAT_W     = 66;

    localparam logic signed [DATA_W-1:0]  REAL_START_RST = -32'sd590558003;
    localparam logic signed [DATA_W-1:0]  REAL_STEP_RST  = 32'sd2516582;
    localparam logic signed [DATA_W-1:0]  IMAG_START_RST = -32'sd402653184;
    localparam logic signed [DATA_W-1:0]  IMAG_STEP_RST  = 32'sd3355443;
    localparam logic [COUNT_W-1:0]        ITER_LIMIT_RST = 16'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REAL_START = 3'd0,
        CFG_REAL_STEP  = 3'd1,
        CFG_IMAG_START = 3'd2,
        CFG_IMAG_STEP  = 3'd3,
        CFG_ITER_LIMIT = 3'd4
    } cfg_index_t;

    // Iteration state carried round the ring of cells
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] cr;
        logic signed [DATA_W-1:0] ci;
        logic [COUNT_W-1:0]       n;
    } mbe_iter_t;

    // Finished point leaving a cell
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } mbe_fin_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[SAT_W-1:DATA_W-1] == '0 || v[SAT_W-1:DATA_W-1] == '1) begin
            r = v[DATA_W-1:0];
        end else if (v[SAT_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: sv/mbe_front.sv
// Coordinate mapping front end: c = start + coord * step, two registered stages.
// Depends on mbe_pkg.
module mbe_front #(
    parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  logic [COORD_BITS-1:0]               in_col,
    input  logic [COORD_BITS-1:0]               in_row,
    input  logic signed [mbe_pkg::DATA_W-1:0]   real_start,
    input  logic signed [mbe_pkg::DATA_W-1:0]   real_step,
    input  logic signed [mbe_pkg::DATA_W-1:0]   imag_start,
    input  logic signed [mbe_pkg::DATA_W-1:0]   imag_step,
    output logic                                out_valid,
    output mbe_pkg::mbe_iter_t                  out_state
);
    import mbe_pkg::*;

    localparam int PROD_W = COORD_BITS + DATA_W + 1;

    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] prod_r_reg, prod_r_next;
    logic signed [PROD_W-1:0] prod_i_reg, prod_i_next;
    logic                     state_valid_reg;
    mbe_iter_t                state_reg, state_next;

    always_comb begin
        prod_r_next = $signed({1'b0, in_col}) * real_step;
        prod_i_next = $signed({1'b0, in_row}) * imag_step;
        state_next    = '0;
        state_next.cr = sat32(SAT_W'(prod_r_reg) + SAT_W'(real_start));
        state_next.ci = sat32(SAT_W'(prod_i_reg) + SAT_W'(imag_start));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg  <= 1'b0;
            state_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg  <= in_valid;
            state_valid_reg <= prod_valid_reg;
        end
        prod_r_reg <= prod_r_next;
        prod_i_reg <= prod_i_next;
        state_reg  <= state_next;
    end

    assign out_valid = state_valid_reg;
    assign out_state = state_reg;

endmodule

FILE: sv/mbe_cell.sv
// One ring cell: escape test and one z = z*z + c step, registered hand-on.
// Depends on mbe_pkg.
module mbe_cell #(
    parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  mbe_pkg::mbe_iter_t            in_state,
    input  logic [mbe_pkg::COUNT_W-1:0]   limit,
    input  logic                          out_free,
    output logic                          out_valid,
    output mbe_pkg::mbe_iter_t            out_state,
    output mbe_pkg::mbe_fin_t             fin
);
    import mbe_pkg::*;

    localparam logic [64:0] FOUR = 65'(4) << FRAC_BITS;

    logic signed [63:0] pxx, pyy, pxy, xy_sh;
    logic [63:0]        sq_x, sq_y;
    logic [64:0]        mag;
    logic signed [SAT_W-1:0] nx_w, ny_w;
    logic               done;
    logic               valid_reg, valid_next;
    mbe_iter_t          state_reg, state_next;

    always_comb begin
        pxx   = in_state.x * in_state.x;
        pyy   = in_state.y * in_state.y;
        pxy   = in_state.x * in_state.y;
        sq_x  = 64'($unsigned(pxx) >> FRAC_BITS);
        sq_y  = 64'($unsigned(pyy) >> FRAC_BITS);
        xy_sh = pxy >>> (FRAC_BITS - 1);
        mag   = {1'b0, sq_x} + {1'b0, sq_y};
        nx_w  = $signed({2'b00, sq_x}) - $signed({2'b00, sq_y}) + SAT_W'(in_state.cr);
        ny_w  = SAT_W'(xy_sh) + SAT_W'(in_state.ci);
        done  = (in_state.n >= limit) || (mag >= FOUR);

        state_next = in_state;
        if (!done) begin
            state_next.x = sat32(nx_w);
            state_next.y = sat32(ny_w);
            state_next.n = in_state.n + COUNT_W'(1);
        end
        // a finished point keeps circulating unchanged while the output is full
        valid_next = in_valid && !(done && out_free);

        fin.valid = in_valid && done && out_free;
        fin.count = (in_state.n < limit) ? in_state.n : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        state_reg <= state_next;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

FILE: sv/mandelbrot_escape_time_core.sv
// Mandelbrot escape-time core, top level: configuration registers, front end
// and a ring of iteration cells. Depends on mbe_pkg, mbe_front, mbe_cell.
//
// Usage:
//   s_ channel: one pixel (col,row) per transaction; mapped to c by the
//   start/step registers in signed Q4.28 and iterated from z = 0.
//   m_ channel: one result per pixel, coordinates echoed with the escape
//   count, 0 when the iteration limit is reached.
//   cfg_ channel: register writes by index, always ready; write only while
//   no pixel is in flight. Unknown indexes are ignored.
// Timing:
//   One pixel in flight at a time. The point moves one cell per cycle round
//   the ring and each cell does one iteration; s_ready rises with m_valid.
// Reset: synchronous, active low; empties the block and restores the
//   default view and a limit of 1024.
// Stall: a result waits in the output register; a further finished point
//   keeps circulating in the ring until that register frees.
module mandelbrot_escape_time_core #(
    parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF,
    parameter int NUM_CELLS  = mbe_pkg::NUM_CELLS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [COORD_BITS-1:0]             s_pixel_col,
    input  logic [COORD_BITS-1:0]             s_pixel_row,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [COORD_BITS-1:0]             m_out_col,
    output logic [COORD_BITS-1:0]             m_out_row,
    output logic [mbe_pkg::COUNT_W-1:0]       m_escape_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbe_pkg::DATA_W-1:0]        cfg_data
);
    import mbe_pkg::*;

    logic signed [DATA_W-1:0] real_start_reg, real_step_reg;
    logic signed [DATA_W-1:0] imag_start_reg, imag_step_reg;
    logic [COUNT_W-1:0]       iter_limit_reg;

    logic                  busy_reg;
    logic [COORD_BITS-1:0] col_reg, row_reg;
    logic                  m_valid_reg;
    logic [COORD_BITS-1:0] m_col_reg, m_row_reg;
    logic [COUNT_W-1:0]    m_count_reg;

    logic      s_fire, out_free;
    logic      front_valid;
    mbe_iter_t front_state;
    logic      entry_valid;
    mbe_iter_t entry_state;

    logic      ring_valid [NUM_CELLS];
    mbe_iter_t ring_state [NUM_CELLS];
    mbe_fin_t  fin        [NUM_CELLS];
    mbe_fin_t  fin_any;

    assign s_fire    = s_valid && s_ready;
    assign s_ready   = !busy_reg;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            real_start_reg <= REAL_START_RST;
            real_step_reg  <= REAL_STEP_RST;
            imag_start_reg <= IMAG_START_RST;
            imag_step_reg  <= IMAG_STEP_RST;
            iter_limit_reg <= ITER_LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_REAL_START: real_start_reg <= cfg_data;
                CFG_REAL_STEP:  real_step_reg  <= cfg_data;
                CFG_IMAG_START: imag_start_reg <= cfg_data;
                CFG_IMAG_STEP:  imag_step_reg  <= cfg_data;
                CFG_ITER_LIMIT: iter_limit_reg <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    mbe_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_fire),
        .in_col     (s_pixel_col),
        .in_row     (s_pixel_row),
        .real_start (real_start_reg),
        .real_step  (real_step_reg),
        .imag_start (imag_start_reg),
        .imag_step  (imag_step_reg),
        .out_valid  (front_valid),
        .out_state  (front_state)
    );

    assign entry_valid = front_valid || ring_valid[NUM_CELLS-1];
    assign entry_state = front_valid ? front_state : ring_state[NUM_CELLS-1];

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        if (k == 0) begin : g_first
            mbe_cell #(
                .FRAC_BITS (FRAC_BITS)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (entry_valid),
                .in_state  (entry_state),
                .limit     (iter_limit_reg),
                .out_free  (out_free),
                .out_valid (ring_valid[k]),
                .out_state (ring_state[k]),
                .fin       (fin[k])
            );
        end else begin : g_rest
            mbe_cell #(
                .FRAC_BITS (FRAC_BITS)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (ring_valid[k-1]),
                .in_state  (ring_state[k-1]),
                .limit     (iter_limit_reg),
                .out_free  (out_free),
                .out_valid (ring_valid[k]),
                .out_state (ring_state[k]),
                .fin       (fin[k])
            );
        end
    end

    always_comb begin
        fin_any = '0;
        for (int k = 0; k < NUM_CELLS; k++) begin
            fin_any.valid = fin_any.valid | fin[k].valid;
            fin_any.count = fin_any.count | (fin[k].valid ? fin[k].count : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                busy_reg <= 1'b1;
            end else if (fin_any.valid) begin
                busy_reg <= 1'b0;
            end
            if (fin_any.valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_fire) begin
            col_reg <= s_pixel_col;
            row_reg <= s_pixel_row;
        end
        if (fin_any.valid) begin
            m_col_reg   <= col_reg;
            m_row_reg   <= row_reg;
            m_count_reg <= fin_any.count;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_col      = m_col_reg;
    assign m_out_row      = m_row_reg;
    assign m_escape_count = m_count_reg;

endmodule
